// File: hw/rtl/scbrt_pkg.sv
// ----------------------------------------------------------------------------
// scbrt_pkg
// Shared types and constants for the sorted code block range table.
// ----------------------------------------------------------------------------
`default_nettype none
package scbrt_pkg;

   localparam int BLK_DEPTH = 256;
   localparam int BLK_IDX_W = $clog2(BLK_DEPTH);
   localparam int BLK_CNT_W = BLK_IDX_W + 1;
   localparam int OFS_DEPTH = 256;
   localparam int OFS_CNT_W = $clog2(OFS_DEPTH) + 1;
   localparam int JMP_DEPTH = 256;
   localparam int JMP_IDX_W = $clog2(JMP_DEPTH);
   localparam int JMP_CNT_W = JMP_IDX_W + 1;
   localparam int FAR_LIMIT = 256;
   localparam int ROLL_COUNT = 255;

   localparam logic [2:0] REQ_START = 3'd0;
   localparam logic [2:0] REQ_POINT = 3'd1;
   localparam logic [2:0] REQ_END   = 3'd2;
   localparam logic [2:0] REQ_LOOK  = 3'd3;
   localparam logic [2:0] REQ_PUSH  = 3'd4;
   localparam logic [2:0] REQ_PULL  = 3'd5;
   localparam logic [2:0] REQ_CLEAR = 3'd6;

   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_BLK_FULL  = 3'd1;
   localparam logic [2:0] STAT_OFS_FULL  = 3'd2;
   localparam logic [2:0] STAT_SPLIT     = 3'd3;
   localparam logic [2:0] STAT_JMP_FULL  = 3'd4;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] addr;
   } req_type_type;

   typedef struct packed {
      logic        hit;
      logic [7:0]  block_index;
      logic [31:0] block_start;
      logic [31:0] block_end;
      logic [8:0]  offsets_base;
      logic [7:0]  offsets_count;
      logic [31:0] jump_target;
      logic [2:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [31:0] bstart;
      logic [31:0] bend;
      logic [8:0]  bbase;
      logic [7:0]  bcount;
   } blk_entry_type;

endpackage
`default_nettype wire

// File: hw/rtl/sorted_code_block_range_table.sv
// ----------------------------------------------------------------------------
// sorted_code_block_range_table
// Sorted table of code blocks with floor lookup and a jump work stack.
// ----------------------------------------------------------------------------
// One request is taken while busy is low; its result appears on rsp_data for
// exactly one cycle with rsp_valid and cannot be stalled. Push, clear and a
// rejected start answer straight from idle. Lookup is a binary search over
// the block memory. Start also shifts each block above the insertion point
// up by one, a read and then a write per block, to make room. Pull repeats
// a lookup per popped target. The block memory has a single read port.
`default_nettype none
module sorted_code_block_range_table
   import scbrt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire req_type_type req_data,
   output logic              rsp_valid,
   output rsp_type           rsp_data
);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_SRCH  = 10'b0000000010,
      ST_SCMP  = 10'b0000000100,
      ST_SHR   = 10'b0000001000,
      ST_SHW   = 10'b0000010000,
      ST_PT    = 10'b0000100000,
      ST_ENDC  = 10'b0001000000,
      ST_LKCHK = 10'b0010000000,
      ST_PULL  = 10'b0100000000,
      ST_PULLT = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [BLK_CNT_W-1:0] lo_ff, lo_in, hi_ff, hi_in, r_ff, r_in;
   logic [BLK_IDX_W-1:0] pos_ff, pos_in;
   logic [31:0] key_ff, key_in;
   logic ins_ff, ins_in, pull_ff, pull_in;
   logic [OFS_CNT_W-1:0] base_new_ff, base_new_in;
   logic [2:0] stat_ff, stat_in;
   logic [BLK_CNT_W-1:0] blocks_used_ff, blocks_used_in;
   logic [BLK_IDX_W-1:0] open_block_ff, open_block_in;
   logic [OFS_CNT_W-1:0] offsets_used_ff, offsets_used_in;
   logic [JMP_CNT_W-1:0] jumps_used_ff, jumps_used_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   blk_entry_type blk_mem [BLK_DEPTH];
   blk_entry_type blk_rd_ff, blk_wdata;
   logic blk_we;
   logic [BLK_IDX_W-1:0] blk_waddr, blk_raddr;

   logic [31:0] jmp_mem [JMP_DEPTH];
   logic [31:0] jmp_rd_ff;
   logic jmp_we;
   logic [JMP_IDX_W-1:0] jmp_raddr;

   logic [BLK_CNT_W-1:0] mid;
   logic [31:0] diff;
   logic split, roll, go_right;
   logic [OFS_CNT_W-1:0] roll_span;
   logic [BLK_CNT_W:0] need_total;
   logic [32:0] cover_end;

   function automatic rsp_type blk_rsp(blk_entry_type e, logic [BLK_IDX_W-1:0] idx,
                                       logic [2:0] st);
      rsp_type r;
      r = '0;
      r.block_index = idx;
      r.block_start = e.bstart;
      r.block_end = e.bend;
      r.offsets_base = e.bbase;
      r.offsets_count = e.bcount;
      r.status = st;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (blk_we) begin
         blk_mem[blk_waddr] <= blk_wdata;
      end
      blk_rd_ff <= blk_mem[blk_raddr];
      if (jmp_we) begin
         jmp_mem[jumps_used_ff[JMP_IDX_W-1:0]] <= req_data.addr;
      end
      jmp_rd_ff <= jmp_mem[jmp_raddr];
   end

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign diff = key_ff - blk_rd_ff.bstart;
   assign split = diff >= 32'(FAR_LIMIT);
   assign roll_span = offsets_used_ff + OFS_CNT_W'(1) - blk_rd_ff.bbase;
   assign roll = !split && (roll_span == OFS_CNT_W'(ROLL_COUNT));
   assign need_total = {1'b0, blocks_used_ff} + (BLK_CNT_W+1)'(split)
                       + (BLK_CNT_W+1)'(roll);
   assign go_right = ins_ff ? (blk_rd_ff.bstart < key_ff) : (blk_rd_ff.bstart <= key_ff);
   assign cover_end = {1'b0, blk_rd_ff.bstart} + {1'b0, blk_rd_ff.bend};
   assign jmp_raddr = JMP_IDX_W'(jumps_used_ff - JMP_CNT_W'(1));

   always_comb begin
      state_in = state_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      r_in = r_ff;
      pos_in = pos_ff;
      key_in = key_ff;
      ins_in = ins_ff;
      pull_in = pull_ff;
      base_new_in = base_new_ff;
      stat_in = stat_ff;
      blocks_used_in = blocks_used_ff;
      open_block_in = open_block_ff;
      offsets_used_in = offsets_used_ff;
      jumps_used_in = jumps_used_ff;
      rsp_valid_in = 1'b0;
      rsp_in = '0;
      blk_we = 1'b0;
      blk_waddr = open_block_ff;
      blk_wdata = blk_rd_ff;
      blk_raddr = open_block_ff;
      jmp_we = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in = req_data.addr;
               lo_in = '0;
               hi_in = blocks_used_ff;
               unique case (req_data.req_type)
                  REQ_START: begin
                     if (blocks_used_ff >= BLK_CNT_W'(BLK_DEPTH)) begin
                        rsp_valid_in = 1'b1;
                        rsp_in.status = STAT_BLK_FULL;
                     end else begin
                        ins_in = 1'b1;
                        base_new_in = offsets_used_ff;
                        stat_in = STAT_OK;
                        state_in = ST_SRCH;
                     end
                  end
                  REQ_POINT, REQ_END: begin
                     if (blocks_used_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = (req_data.req_type == REQ_POINT) ? ST_PT : ST_ENDC;
                     end
                  end
                  REQ_LOOK: begin
                     ins_in = 1'b0;
                     pull_in = 1'b0;
                     state_in = ST_SRCH;
                  end
                  REQ_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (jumps_used_ff >= JMP_CNT_W'(JMP_DEPTH)) begin
                        rsp_in.status = STAT_JMP_FULL;
                     end else begin
                        jmp_we = 1'b1;
                        jumps_used_in = jumps_used_ff + JMP_CNT_W'(1);
                     end
                  end
                  REQ_PULL: begin
                     ins_in = 1'b0;
                     pull_in = 1'b1;
                     state_in = ST_PULL;
                  end
                  REQ_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     blocks_used_in = '0;
                     open_block_in = '0;
                     offsets_used_in = '0;
                     jumps_used_in = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SRCH: begin
            if (lo_ff < hi_ff) begin
               blk_raddr = mid[BLK_IDX_W-1:0];
               state_in = ST_SCMP;
            end else if (ins_ff) begin
               pos_in = lo_ff[BLK_IDX_W-1:0];
               r_in = blocks_used_ff;
               state_in = ST_SHR;
            end else if (lo_ff == '0) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
               if (pull_ff) begin
                  rsp_in.hit = 1'b1;
                  rsp_in.jump_target = key_ff;
               end
            end else begin
               blk_raddr = BLK_IDX_W'(lo_ff - BLK_CNT_W'(1));
               state_in = ST_LKCHK;
            end
         end
         ST_SCMP: begin
            if (go_right) begin
               lo_in = mid + BLK_CNT_W'(1);
            end else begin
               hi_in = mid;
            end
            state_in = ST_SRCH;
         end
         ST_SHR: begin
            if (r_ff > {1'b0, pos_ff}) begin
               blk_raddr = BLK_IDX_W'(r_ff - BLK_CNT_W'(1));
               state_in = ST_SHW;
            end else begin
               blk_we = 1'b1;
               blk_waddr = pos_ff;
               blk_wdata = '{bstart: key_ff, bend: 32'd1, bbase: base_new_ff, bcount: 8'd0};
               open_block_in = pos_ff;
               blocks_used_in = blocks_used_ff + BLK_CNT_W'(1);
               rsp_valid_in = 1'b1;
               rsp_in = blk_rsp(blk_wdata, pos_ff, stat_ff);
               state_in = ST_IDLE;
            end
         end
         ST_SHW: begin
            blk_we = 1'b1;
            blk_waddr = r_ff[BLK_IDX_W-1:0];
            r_in = r_ff - BLK_CNT_W'(1);
            state_in = ST_SHR;
         end
         ST_PT: begin
            lo_in = '0;
            hi_in = blocks_used_ff;
            ins_in = 1'b1;
            if (diff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_in = blk_rsp(blk_rd_ff, open_block_ff, STAT_OK);
               state_in = ST_IDLE;
            end else if (offsets_used_ff >= OFS_CNT_W'(OFS_DEPTH)) begin
               rsp_valid_in = 1'b1;
               rsp_in = blk_rsp(blk_rd_ff, open_block_ff, STAT_OFS_FULL);
               state_in = ST_IDLE;
            end else if (need_total > (BLK_CNT_W+1)'(BLK_DEPTH)) begin
               rsp_valid_in = 1'b1;
               rsp_in = blk_rsp(blk_rd_ff, open_block_ff, STAT_BLK_FULL);
               state_in = ST_IDLE;
            end else if (split) begin
               blk_we = 1'b1;
               blk_wdata.bend = diff;
               blk_wdata.bcount = 8'(offsets_used_ff - blk_rd_ff.bbase);
               base_new_in = offsets_used_ff;
               offsets_used_in = offsets_used_ff + OFS_CNT_W'(1);
               stat_in = STAT_SPLIT;
               state_in = ST_SRCH;
            end else if (roll) begin
               blk_we = 1'b1;
               blk_wdata.bend = diff;
               blk_wdata.bcount = 8'(roll_span);
               base_new_in = offsets_used_ff + OFS_CNT_W'(1);
               offsets_used_in = offsets_used_ff + OFS_CNT_W'(1);
               stat_in = STAT_OK;
               state_in = ST_SRCH;
            end else begin
               offsets_used_in = offsets_used_ff + OFS_CNT_W'(1);
               rsp_valid_in = 1'b1;
               rsp_in = blk_rsp(blk_rd_ff, open_block_ff, STAT_OK);
               state_in = ST_IDLE;
            end
         end
         ST_ENDC: begin
            blk_we = 1'b1;
            blk_wdata.bend = diff;
            blk_wdata.bcount = 8'(offsets_used_ff - blk_rd_ff.bbase);
            rsp_valid_in = 1'b1;
            rsp_in = blk_rsp(blk_wdata, open_block_ff, STAT_OK);
            state_in = ST_IDLE;
         end
         ST_LKCHK: begin
            if ({1'b0, key_ff} <= cover_end) begin
               if (pull_ff) begin
                  state_in = ST_PULL;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in = blk_rsp(blk_rd_ff, BLK_IDX_W'(lo_ff - BLK_CNT_W'(1)), STAT_OK);
                  rsp_in.hit = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
               if (pull_ff) begin
                  rsp_in.hit = 1'b1;
                  rsp_in.jump_target = key_ff;
               end
            end
         end
         ST_PULL: begin
            if (jumps_used_ff == '0) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               jumps_used_in = jumps_used_ff - JMP_CNT_W'(1);
               state_in = ST_PULLT;
            end
         end
         ST_PULLT: begin
            key_in = jmp_rd_ff;
            lo_in = '0;
            hi_in = blocks_used_ff;
            state_in = ST_SRCH;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         blocks_used_ff <= '0;
         open_block_ff <= '0;
         offsets_used_ff <= '0;
         jumps_used_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         blocks_used_ff <= blocks_used_in;
         open_block_ff <= open_block_in;
         offsets_used_ff <= offsets_used_in;
         jumps_used_ff <= jumps_used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      r_ff <= r_in;
      pos_ff <= pos_in;
      key_ff <= key_in;
      ins_ff <= ins_in;
      pull_ff <= pull_in;
      base_new_ff <= base_new_in;
      stat_ff <= stat_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result shown while busy");
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid)) else $error("transfer lost");
   a_blocks_bound: assert property (@(posedge clock) disable iff (reset)
      blocks_used_ff <= BLK_CNT_W'(BLK_DEPTH)) else $error("block count overflow");
   a_open_in_range: assert property (@(posedge clock) disable iff (reset)
      (blocks_used_ff != '0) |-> ({1'b0, open_block_ff} < blocks_used_ff))
      else $error("open block out of range");
`endif

endmodule
`default_nettype wire

// File: verif/tb_sorted_code_block_range_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_code_block_range_table
// Self-checking bench for the sorted code block range table. Command
// transfers are drawn from directed cases and random episodes of block
// building, lookups and jump stack traffic. A predictor in the bench keeps
// its own block table, offset store and jump stack and works out the
// response of every accepted command. A monitor compares each response
// field by field, in order, against what the predictor expects.
// ----------------------------------------------------------------------------
module tb_sorted_code_block_range_table;
   import scbrt_pkg::*;

   localparam logic [2:0] REQ_UNUSED = 3'd7;

   typedef struct {
      req_type_type cmd;
      int unsigned  gap;
   } pending_cmd_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   req_type_type req_data = '0;
   logic         busy;
   logic         rsp_valid;
   rsp_type      rsp_data;

   pending_cmd_type pending_cmds[$];
   rsp_type         expected_rsps[$];
   int unsigned     idle_left = 0;
   int unsigned     error_count = 0;

   // predictor state
   logic [31:0] blk_start [BLK_DEPTH];
   logic [31:0] blk_end   [BLK_DEPTH];
   logic [8:0]  blk_base  [BLK_DEPTH];
   logic [7:0]  blk_count [BLK_DEPTH];
   logic [7:0]  offset_mem [OFS_DEPTH];
   logic [31:0] jump_mem  [JMP_DEPTH];
   int unsigned blocks_used = 0;
   int unsigned open_idx = 0;
   int unsigned offsets_used = 0;
   int unsigned jumps_used = 0;

   sorted_code_block_range_table u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int floor_index(logic [31:0] a);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = blocks_used;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (blk_start[mid] <= a) lo = mid + 1;
         else hi = mid;
      end
      return int'(lo) - 1;
   endfunction

   function automatic int covering_block(logic [31:0] a);
      int i;
      i = floor_index(a);
      if (i < 0) return -1;
      if ({32'd0, a} > {32'd0, blk_start[i]} + {32'd0, blk_end[i]}) return -1;
      return i;
   endfunction

   function automatic void fill_block(ref rsp_type r, input int unsigned i);
      r.block_index   = i[7:0];
      r.block_start   = blk_start[i];
      r.block_end     = blk_end[i];
      r.offsets_base  = blk_base[i];
      r.offsets_count = blk_count[i];
   endfunction

   function automatic void insert_block(logic [31:0] a);
      int unsigned pos;
      pos = 0;
      while (pos < blocks_used && blk_start[pos] < a) pos++;
      for (int unsigned r = blocks_used; r > pos; r--) begin
         blk_start[r] = blk_start[r-1];
         blk_end[r]   = blk_end[r-1];
         blk_base[r]  = blk_base[r-1];
         blk_count[r] = blk_count[r-1];
      end
      blk_start[pos] = a;
      blk_end[pos]   = 32'd1;
      blk_base[pos]  = offsets_used[8:0];
      blk_count[pos] = 8'd0;
      open_idx = pos;
      blocks_used++;
   endfunction

   function automatic void close_block(logic [31:0] a);
      int unsigned n;
      n = offsets_used - blk_base[open_idx];
      blk_end[open_idx]   = a - blk_start[open_idx];
      blk_count[open_idx] = n[7:0];
   endfunction

   function automatic rsp_type predict_rsp(req_type_type c);
      rsp_type     r;
      logic [31:0] a, diff, t;
      int unsigned base_after, need;
      logic        split, roll;
      int          i;
      r = '0;
      a = c.addr;
      case (c.req_type)
         REQ_START: begin
            if (blocks_used >= BLK_DEPTH) r.status = STAT_BLK_FULL;
            else begin
               insert_block(a);
               fill_block(r, open_idx);
            end
         end
         REQ_POINT: begin
            if (blocks_used != 0) begin
               diff = a - blk_start[open_idx];
               if (diff == 0) fill_block(r, open_idx);
               else if (offsets_used >= OFS_DEPTH) begin
                  r.status = STAT_OFS_FULL;
                  fill_block(r, open_idx);
               end else begin
                  split = diff >= FAR_LIMIT;
                  base_after = split ? offsets_used : blk_base[open_idx];
                  roll = (offsets_used + 1 - base_after) == ROLL_COUNT;
                  need = split + roll;
                  if (blocks_used + need > BLK_DEPTH) begin
                     r.status = STAT_BLK_FULL;
                     fill_block(r, open_idx);
                  end else begin
                     if (split) begin
                        close_block(a);
                        insert_block(a);
                        diff = 0;
                     end
                     offset_mem[offsets_used] = diff[7:0];
                     offsets_used++;
                     if (roll) begin
                        close_block(a);
                        insert_block(a);
                     end
                     fill_block(r, open_idx);
                     r.status = split ? STAT_SPLIT : STAT_OK;
                  end
               end
            end
         end
         REQ_END: begin
            if (blocks_used != 0) begin
               close_block(a);
               fill_block(r, open_idx);
            end
         end
         REQ_LOOK: begin
            i = covering_block(a);
            if (i >= 0) begin
               r.hit = 1'b1;
               fill_block(r, i);
            end
         end
         REQ_PUSH: begin
            if (jumps_used >= JMP_DEPTH) r.status = STAT_JMP_FULL;
            else begin
               jump_mem[jumps_used] = a;
               jumps_used++;
            end
         end
         REQ_PULL: begin
            while (jumps_used > 0) begin
               jumps_used--;
               t = jump_mem[jumps_used];
               if (covering_block(t) < 0) begin
                  r.hit = 1'b1;
                  r.jump_target = t;
                  break;
               end
            end
         end
         REQ_CLEAR: begin
            blocks_used = 0;
            open_idx = 0;
            offsets_used = 0;
            jumps_used = 0;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
   endtask

   // driver
   always @(posedge clock) begin
      pending_cmd_type nxt;
      logic            go;
      if (reset) begin
         start <= 1'b0;
         idle_left = 0;
      end else begin
         go = start;
         if (start && !busy) begin
            expected_rsps.push_back(predict_rsp(req_data));
            go = 1'b0;
         end
         if (!go) begin
            if (idle_left > 0) idle_left--;
            else if (pending_cmds.size() > 0) begin
               nxt = pending_cmds.pop_front();
               req_data <= nxt.cmd;
               idle_left = nxt.gap;
               go = 1'b1;
            end
         end
         start <= go;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) report_mismatch("unexpected transfer", 0, 0);
         else begin
            want = expected_rsps.pop_front();
            if (rsp_data.hit != want.hit)
               report_mismatch("hit", rsp_data.hit, want.hit);
            if (rsp_data.block_index != want.block_index)
               report_mismatch("block_index", rsp_data.block_index, want.block_index);
            if (rsp_data.block_start != want.block_start)
               report_mismatch("block_start", rsp_data.block_start, want.block_start);
            if (rsp_data.block_end != want.block_end)
               report_mismatch("block_end", rsp_data.block_end, want.block_end);
            if (rsp_data.offsets_base != want.offsets_base)
               report_mismatch("offsets_base", rsp_data.offsets_base, want.offsets_base);
            if (rsp_data.offsets_count != want.offsets_count)
               report_mismatch("offsets_count", rsp_data.offsets_count,
                               want.offsets_count);
            if (rsp_data.jump_target != want.jump_target)
               report_mismatch("jump_target", rsp_data.jump_target, want.jump_target);
            if (rsp_data.status != want.status)
               report_mismatch("status", rsp_data.status, want.status);
         end
      end
   end

   task automatic add_cmd(logic [2:0] kind, logic [31:0] a);
      pending_cmd_type p;
      p.cmd.req_type = kind;
      p.cmd.addr = a;
      p.gap = $urandom_range(0, 14);
      pending_cmds.push_back(p);
   endtask

   // well-formed block building with random content, plus some noise
   task automatic build_episode(logic [31:0] region);
      logic [31:0] cur;
      int unsigned nblk, npts;
      if ($urandom_range(0, 2) == 0) add_cmd(REQ_CLEAR, 0);
      nblk = $urandom_range(1, 6);
      for (int b = 0; b < nblk; b++) begin
         cur = region + $urandom_range(0, 4000);
         add_cmd(REQ_START, cur);
         npts = $urandom_range(0, 8);
         for (int p = 0; p < npts; p++) begin
            case ($urandom_range(0, 9))
               0: cur = cur + $urandom_range(256, 600);
               1: ;
               default: cur = cur + $urandom_range(1, 60);
            endcase
            add_cmd(REQ_POINT, cur);
         end
         add_cmd(REQ_END, cur + $urandom_range(0, 8));
         for (int k = $urandom_range(0, 3); k > 0; k--)
            add_cmd(REQ_LOOK, region + $urandom_range(0, 4600));
         if ($urandom_range(0, 1)) add_cmd(REQ_PUSH, region + $urandom_range(0, 4600));
      end
      for (int k = $urandom_range(0, 3); k > 0; k--)
         add_cmd(REQ_PULL, 0);
      if ($urandom_range(0, 4) == 0)
         add_cmd(3'($urandom_range(0, 7)), $urandom);
   endtask

   initial begin
      logic [31:0] base;
      // directed cases
      add_cmd(REQ_POINT, 32'h10);
      add_cmd(REQ_END, 32'h10);
      add_cmd(REQ_PULL, 0);
      add_cmd(REQ_LOOK, 32'h0);
      add_cmd(REQ_START, 32'h1000);
      add_cmd(REQ_POINT, 32'h1000);
      add_cmd(REQ_POINT, 32'h1005);
      add_cmd(REQ_POINT, 32'h10FF);
      add_cmd(REQ_POINT, 32'h1300);
      add_cmd(REQ_END, 32'h1310);
      add_cmd(REQ_START, 32'h1000);
      add_cmd(REQ_START, 32'h0);
      add_cmd(REQ_START, 32'hFFFF_FFFF);
      add_cmd(REQ_END, 32'hFFFF_FFFF);
      add_cmd(REQ_LOOK, 32'hFFFF_FFFF);
      add_cmd(REQ_LOOK, 32'h1310);
      add_cmd(REQ_LOOK, 32'h1311);
      add_cmd(REQ_LOOK, 32'h0FFF);
      add_cmd(REQ_PUSH, 32'h1301);
      add_cmd(REQ_PUSH, 32'h2000);
      add_cmd(REQ_PUSH, 32'h1002);
      add_cmd(REQ_PULL, 0);
      add_cmd(REQ_PULL, 0);
      add_cmd(REQ_UNUSED, 32'hFFFF_FFFF);
      add_cmd(REQ_CLEAR, 0);

      // random episodes, with one pass each at the capacity limits
      for (int ep = 0; pending_cmds.size() < 1180; ep++) begin
         base = $urandom;
         case (ep)
            4: begin
               add_cmd(REQ_CLEAR, 0);
               add_cmd(REQ_START, base);
               for (int k = 1; k <= 300; k++)
                  add_cmd(REQ_POINT, base + k - (k > 255 ? 255 : 0));
               add_cmd(REQ_END, base + $urandom_range(0, 300));
               for (int k = 0; k < 6; k++) add_cmd(REQ_LOOK, base + $urandom_range(0, 320));
            end
            9: begin
               add_cmd(REQ_CLEAR, 0);
               for (int k = 0; k < 258; k++) add_cmd(REQ_START, base + $urandom_range(0, 2000));
               add_cmd(REQ_POINT, $urandom);
               for (int k = 0; k < 6; k++) add_cmd(REQ_LOOK, base + $urandom_range(0, 2100));
            end
            14: begin
               for (int k = 0; k < 258; k++) add_cmd(REQ_PUSH, $urandom);
               for (int k = 0; k < 4; k++) add_cmd(REQ_PULL, 0);
               add_cmd(REQ_CLEAR, 0);
            end
            default: build_episode(base);
         endcase
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (pending_cmds.size() != 0 || start || expected_rsps.size() != 0);
      repeat (600) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #100_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/scbrt_pkg.sv
hw/rtl/sorted_code_block_range_table.sv
verif/tb_sorted_code_block_range_table.sv
